// ===== rtl/core/spsg_pkg.sv =====
package spsg_pkg;

    localparam int unsigned TICK_US        = 10;
    localparam int unsigned MIN_PERIOD_US  = 100;
    localparam int unsigned IDLE_PERIOD_US = 1000000;
    localparam int unsigned RATE_SCALE     = 1000;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_TARGET = 2'd2;

    localparam logic [2:0] REG_CLOSED_LOOP = 3'd0;
    localparam logic [2:0] REG_P_GAIN      = 3'd1;
    localparam logic [2:0] REG_I_GAIN      = 3'd2;
    localparam logic [2:0] REG_D_GAIN      = 3'd3;
    localparam logic [2:0] REG_INT_LIMIT   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DIV_D,
        ST_SUM,
        ST_START_V,
        ST_DIV_V,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic do_tick;
        logic do_target;
        logic do_err;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic div_start_d;
        logic add_d;
        logic do_sum;
        logic div_start_v;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       div_busy;
        logic       dt_zero;
        logic       vel_zero;
    } status_t;

endpackage

// ===== rtl/core/spsg_div.sv =====
module spsg_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [95:0]  dividend,
    input  logic [31:0]  divisor,
    output logic         busy,
    output logic [95:0]  quotient
);
    logic [95:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [33:0] trial;

    assign trial    = {rem_reg, quo_reg[95]} - {2'b00, dvs_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd96;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[94:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[31:0], quo_reg[95]};
                quo_reg <= {quo_reg[94:0], 1'b0};
            end
        end
    end
endmodule

// ===== rtl/core/spsg_datapath.sv =====
module spsg_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spsg_pkg::cmd_t       cmd,
    output spsg_pkg::status_t    status,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [95:0]          in_data,
    output logic [87:0]          out_data
);
    import spsg_pkg::*;

    logic        closed_loop_reg;
    logic [31:0] p_gain_reg, i_gain_reg, d_gain_reg;
    logic [30:0] int_limit_reg;

    logic signed [31:0] setpoint_reg, position_reg, velocity_reg;
    logic signed [31:0] error_sum_reg;
    logic signed [32:0] last_error_reg;
    logic [19:0]        period_reg, elapsed_reg;
    logic               step_reg, dir_wanted_reg, dir_reg, stepped_reg;

    logic [1:0]         mode_reg;
    logic signed [31:0] enc_reg;
    logic signed [31:0] tgt_reg;
    logic [23:0]        dt_reg;

    logic signed [32:0] err_reg;
    logic signed [33:0] de_reg;
    logic signed [97:0] acc_reg;
    logic               dneg_reg;

    logic [87:0] out_reg;

    logic [32:0] mag_a;
    logic [31:0] gain_sel;
    logic [64:0] prod;
    logic signed [97:0] prod_s;
    logic        neg_sel;

    logic        div_start, div_busy;
    logic [95:0] div_dividend, div_q;
    logic [31:0] div_divisor;
    logic signed [97:0] dq_s;

    logic signed [33:0] es_sum;
    logic signed [33:0] lim_pos, lim_neg;
    logic signed [32:0] err_new;
    logic signed [97:0] tot_abs;
    logic        tot_neg;
    logic [81:0] qv;
    logic signed [31:0] vel_new;
    logic [19:0] elapsed_inc;
    logic signed [32:0] diff;
    logic [31:0] vel_abs;

    assign err_new = 33'(setpoint_reg) - 33'(position_reg);
    assign es_sum  = 34'(error_sum_reg) + 34'(err_reg);
    assign lim_pos = 34'($signed({1'b0, int_limit_reg}));
    assign lim_neg = -lim_pos;

    always_comb
    begin
        mag_a    = '0;
        gain_sel = p_gain_reg;
        neg_sel  = 1'b0;
        if (cmd.mul_p)
        begin
            neg_sel  = err_reg[32];
            mag_a    = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
            gain_sel = p_gain_reg;
        end
        else if (cmd.mul_i)
        begin
            neg_sel  = error_sum_reg[31];
            mag_a    = error_sum_reg[31] ? 33'(-33'(error_sum_reg)) : 33'(error_sum_reg);
            gain_sel = i_gain_reg;
        end
        else if (cmd.mul_d)
        begin
            neg_sel  = de_reg[33];
            mag_a    = de_reg[33] ? 33'(-de_reg) : 33'(de_reg);
            gain_sel = d_gain_reg;
        end
    end

    assign prod   = 65'(mag_a) * 65'(gain_sel);
    assign prod_s = neg_sel ? -$signed({33'd0, prod}) : $signed({33'd0, prod});

    assign div_start    = cmd.div_start_d | cmd.div_start_v;
    assign div_dividend = cmd.div_start_d ? 96'(prod) : 96'(RATE_SCALE);
    assign div_divisor  = cmd.div_start_d ? 32'(dt_reg) : vel_abs;

    spsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign dq_s = dneg_reg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

    assign tot_neg = acc_reg[97];
    assign tot_abs = tot_neg ? -acc_reg : acc_reg;
    assign qv      = tot_abs[97:16];
    always_comb
    begin
        if (tot_neg)
        begin
            vel_new = (qv > 82'h80000000) ? 32'sh80000000 : 32'(-$signed({1'b0, qv[31:0]}));
        end
        else
        begin
            vel_new = (qv > 82'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(qv[31:0]);
        end
    end

    assign vel_abs     = velocity_reg[31] ? 32'(-velocity_reg) : 32'(velocity_reg);
    assign elapsed_inc = elapsed_reg + 20'(TICK_US);
    assign diff        = 33'(setpoint_reg) - 33'(position_reg);

    assign status.mode     = mode_reg;
    assign status.div_busy = div_busy;
    assign status.dt_zero  = (dt_reg == '0);
    assign status.vel_zero = (velocity_reg == '0);
    assign out_data        = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_loop_reg <= 1'b1;
            p_gain_reg      <= 32'd19661;
            i_gain_reg      <= 32'd32768;
            d_gain_reg      <= 32'd655;
            int_limit_reg   <= 31'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLOSED_LOOP: closed_loop_reg <= cfg_data[0];
                REG_P_GAIN:      p_gain_reg      <= cfg_data;
                REG_I_GAIN:      i_gain_reg      <= cfg_data;
                REG_D_GAIN:      d_gain_reg      <= cfg_data;
                REG_INT_LIMIT:   int_limit_reg   <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg   <= '0;
            position_reg   <= '0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            velocity_reg   <= '0;
            period_reg     <= 20'(IDLE_PERIOD_US);
            elapsed_reg    <= '0;
            step_reg       <= 1'b0;
            dir_wanted_reg <= 1'b0;
            dir_reg        <= 1'b0;
            stepped_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                stepped_reg <= 1'b0;
            end
            if (cmd.do_target)
            begin
                setpoint_reg <= tgt_reg;
            end
            if (cmd.do_tick)
            begin
                if (elapsed_inc >= period_reg)
                begin
                    if (!step_reg)
                    begin
                        dir_reg <= dir_wanted_reg;
                    end
                    step_reg    <= ~step_reg;
                    stepped_reg <= 1'b1;
                    elapsed_reg <= '0;
                    if (!closed_loop_reg)
                    begin
                        if (diff >= 33'sd1)
                        begin
                            position_reg <= position_reg + 32'sd1;
                        end
                        else if (diff <= -33'sd1)
                        begin
                            position_reg <= position_reg - 32'sd1;
                        end
                    end
                end
                else
                begin
                    elapsed_reg <= elapsed_inc;
                end
            end
            if (cmd.mul_p)
            begin
                if (es_sum > lim_pos)
                begin
                    error_sum_reg <= 32'(lim_pos);
                end
                else if (es_sum < lim_neg)
                begin
                    error_sum_reg <= 32'(lim_neg);
                end
                else
                begin
                    error_sum_reg <= 32'(es_sum);
                end
            end
            if (cmd.do_sum)
            begin
                last_error_reg <= err_reg;
                velocity_reg   <= vel_new;
                dir_wanted_reg <= (vel_new > 32'sd0);
            end
            if (cmd.finish)
            begin
                if (velocity_reg == '0)
                begin
                    period_reg <= 20'(IDLE_PERIOD_US);
                end
                else if (div_q <= 96'(MIN_PERIOD_US))
                begin
                    period_reg <= 20'(MIN_PERIOD_US);
                end
                else
                begin
                    period_reg <= div_q[19:0];
                end
                if (closed_loop_reg)
                begin
                    position_reg <= enc_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data[1:0];
            enc_reg  <= $signed(in_data[33:2]);
            dt_reg   <= in_data[57:34];
            tgt_reg  <= $signed(in_data[89:58]);
        end
        if (cmd.do_err)
        begin
            err_reg <= err_new;
            de_reg  <= 34'(err_new) - 34'(last_error_reg);
            acc_reg <= '0;
        end
        if (cmd.mul_p)
        begin
            acc_reg <= prod_s;
        end
        if (cmd.mul_i)
        begin
            acc_reg <= acc_reg + prod_s;
        end
        if (cmd.mul_d)
        begin
            dneg_reg <= neg_sel;
        end
        if (cmd.add_d)
        begin
            acc_reg <= acc_reg + dq_s;
        end
        if (cmd.out_load)
        begin
            out_reg <= {1'b0, velocity_reg, position_reg, period_reg, stepped_reg,
                        dir_reg, step_reg};
        end
    end
endmodule

// ===== rtl/core/spsg_ctrl.sv =====
module spsg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  spsg_pkg::status_t status,
    output spsg_pkg::cmd_t    cmd
);
    import spsg_pkg::*;

    state_t state_reg, state_next;
    logic   oval_reg, oval_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    assign out_valid = oval_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_ERR;
            ST_ERR:
            begin
                if (status.mode == MODE_UPDATE) state_next = ST_MUL_P;
                else                            state_next = ST_OUT;
            end
            ST_MUL_P:   state_next = ST_MUL_I;
            ST_MUL_I:   state_next = status.dt_zero ? ST_SUM : ST_MUL_D;
            ST_MUL_D:   state_next = ST_DIV_D;
            ST_DIV_D:   if (!status.div_busy) state_next = ST_SUM;
            ST_SUM:     state_next = ST_START_V;
            ST_START_V: state_next = ST_DIV_V;
            ST_DIV_V:   if (!status.div_busy) state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_OUT;
            ST_OUT:     if (!oval_reg || out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        oval_next = oval_reg;
        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end
        if (state_reg == ST_OUT && (!oval_reg || out_ready))
        begin
            oval_next = 1'b1;
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.load = in_valid;
            ST_ERR:
            begin
                cmd.do_err    = 1'b1;
                cmd.do_tick   = (status.mode == MODE_TICK);
                cmd.do_target = (status.mode == MODE_TARGET);
            end
            ST_MUL_P:  cmd.mul_p = 1'b1;
            ST_MUL_I:  cmd.mul_i = 1'b1;
            ST_MUL_D:
            begin
                cmd.mul_d       = 1'b1;
                cmd.div_start_d = 1'b1;
            end
            ST_DIV_D:   cmd.add_d = !status.div_busy;
            ST_SUM:     cmd.do_sum = 1'b1;
            ST_START_V: cmd.div_start_v = 1'b1;
            ST_DIV_V:   ;
            ST_FINISH:  cmd.finish = 1'b1;
            ST_OUT:     cmd.out_load = !oval_reg || out_ready;
            default:    ;
        endcase
    end
endmodule

// ===== rtl/core/stepper_pid_step_generator_top.sv =====
// Sequence: tick, target and unused-mode beats go from the error state to the output
// state; a control update also runs the P and I products, then, unless elapsed time
// is zero, the D product and derivative divide, then the period divide, both on the
// bit-serial divider. Throughput: one beat in flight; the next is accepted once idle.
// Reset: rst_n async active low; FSM, config and loop registers return to power-up values.
module stepper_pid_step_generator_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // mode, encoder_count, elapsed_us, target_position
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,  // step_level, direction_level, stepped, period_us,
                                        // position_now, velocity_out
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import spsg_pkg::*;

    cmd_t    cmd;
    status_t status;

    spsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    spsg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata)
    );
endmodule

// ===== rtl/core/spsg_checker.sv =====
module spsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_period_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[22:3] >= 20'd100)
        else $error("period below floor");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted while busy");

    a_stepped_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] && m_axis_tdata[0] |-> m_axis_tdata[22:3] != 20'd0)
        else $error("step without period");
endmodule

bind stepper_pid_step_generator_top spsg_checker u_spsg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
